/* hdl/amee_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package amee_pkg;

  // Field widths of the items and registers
  localparam int unsigned CfgW   = 11;
  localparam int unsigned AlphaW = 8;
  localparam int unsigned LineW  = 10;

  // Size limits and reset value of the size registers
  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned MaxHeight    = 1024;
  localparam int unsigned SizeResetVal = 1024;

  // Result queue
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_IMAGE_HEIGHT    = 2'd1,
    REG_ALPHA_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_ROW = 1'b0,
    KIND_COL = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [LineW-1:0]   line_index;
    logic               present;
    logic [LineW-1:0]   low_edge;
    logic [LineW-1:0]   high_edge;
    logic               last;
  } result_t;

  // One column store entry
  typedef struct packed {
    logic             found;
    logic [LineW-1:0] lowest;
    logic [LineW-1:0] highest;
  } col_entry_t;

  // Per-pixel request to the column store
  typedef struct packed {
    logic             first_row;
    logic             full;
    logic [LineW-1:0] row;
  } col_req_t;

endpackage

`default_nettype wire

/* hdl/amee_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module amee_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/amee_col_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module amee_col_store import amee_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidth,
  localparam int unsigned Xw = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  input  wire logic [Xw-1:0] req_addr_i,
  input  wire col_req_t      req_i,
  output result_t            col_result_o
);

  localparam int unsigned EntryW = $bits(col_entry_t);

  logic             s1_valid_q;
  logic [Xw-1:0]    s1_addr_q;
  col_req_t         s1_req_q;
  logic             fwd_hit_q, fwd_hit_d;
  col_entry_t       fwd_data_q;
  logic [EntryW-1:0] rd_data;
  col_entry_t       old_entry, new_entry;

  amee_ram #(
    .Width(EntryW),
    .Depth(MAX_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_addr_q),
    .wdata_i(new_entry),
    .re_i   (req_valid_i),
    .raddr_i(req_addr_i),
    .rdata_o(rd_data)
  );

  // Read in the same cycle as a write to the same column returns stale data
  assign fwd_hit_d = req_valid_i && s1_valid_q && (s1_addr_q == req_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= req_valid_i;
      if (req_valid_i) begin
        fwd_hit_q <= fwd_hit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      s1_addr_q  <= req_addr_i;
      s1_req_q   <= req_i;
      fwd_data_q <= new_entry;
    end
  end

  // Modify: the first row overwrites, later rows merge
  always_comb begin
    old_entry = fwd_hit_q ? fwd_data_q : col_entry_t'(rd_data);
    new_entry = old_entry;
    if (s1_req_q.first_row) begin
      new_entry.found   = s1_req_q.full;
      new_entry.lowest  = s1_req_q.full ? s1_req_q.row : '0;
      new_entry.highest = s1_req_q.full ? s1_req_q.row : '0;
    end else if (s1_req_q.full) begin
      new_entry.found   = 1'b1;
      new_entry.lowest  = old_entry.found ? old_entry.lowest : s1_req_q.row;
      new_entry.highest = s1_req_q.row;
    end
  end

  always_comb begin
    col_result_o            = '0;
    col_result_o.kind       = KIND_COL;
    col_result_o.line_index = LineW'(s1_addr_q);
    col_result_o.present    = new_entry.found;
    col_result_o.low_edge   = new_entry.found ? new_entry.lowest  : '0;
    col_result_o.high_edge  = new_entry.found ? new_entry.highest : '0;
  end

  a_fwd_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && fwd_hit_d) |=> (s1_valid_q && fwd_hit_q && $past(s1_valid_q)))
    else $error("forwarding hit without a write in flight");

endmodule

`default_nettype wire

/* hdl/amee_result_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module amee_result_fifo import amee_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [1:0]          push_cnt_i,
  input  wire result_t             wdata0_i,
  input  wire result_t             wdata1_i,
  input  wire logic                pop_i,
  output result_t                  rdata_o,
  output logic [FifoCntW-1:0]      count_o
);

  result_t             entry_q [FifoDepth];
  logic [FifoAw-1:0]   head_q, head_d;
  logic [FifoAw-1:0]   tail_q, tail_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic [FifoAw-1:0]   tail_nxt;

  assign tail_nxt = tail_q + FifoAw'(1);

  always_comb begin
    head_d  = pop_i ? head_q + FifoAw'(1) : head_q;
    tail_d  = tail_q + FifoAw'(push_cnt_i);
    count_d = count_q + FifoCntW'(push_cnt_i) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entry_q[tail_q] <= wdata0_i;
    end
    if (push_cnt_i == 2'd2) begin
      entry_q[tail_nxt] <= wdata1_i;
    end
  end

  assign rdata_o = entry_q[head_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} + (FifoCntW + 1)'(push_cnt_i)) <= (FifoCntW + 1)'(FifoDepth))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("result queue underflow");

endmodule

`default_nettype wire

/* hdl/alpha_mask_edge_extents_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Alpha-mask edge extents.
// Input channel (in_valid_i / in_stall_o / alpha_i): one alpha item per pixel,
// raster order, bottom row first and left to right. A pixel is full when its
// alpha is above the threshold register.
// Output channel (out_valid_o / out_stall_i / result fields): a row item at
// the last pixel of every row, a column item at every pixel of the top row.
// At the last pixel of the top row the column item comes first; last_o marks
// the final item a pixel causes.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; write only while
// idle. Sizes of 0 act as 1, sizes above the maximum act as the maximum.
// Throughput: one pixel per cycle while in_stall_o is low, set by the single
// read port and single write port of the column store (read one cycle, modify
// and write back the next, forwarding between neighbors on the same column).
// Items are registered in the second stage, then queued before output.
// A pixel that causes two items fills the queue twice as fast as it drains.
// Stall: results wait in an eight-entry queue; the input stalls once the
// queue lacks room for the pixel in flight plus one more.
// Reset: position and row extents clear, registers return to full size and
// threshold 0. The column store needs no clearing: row 0 writes each column.
module alpha_mask_edge_extents_unit import amee_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidth,
  parameter int unsigned MAX_HEIGHT = MaxHeight
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [AlphaW-1:0] alpha_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   kind_o,
  output logic [LineW-1:0]       line_index_o,
  output logic                   present_o,
  output logic [LineW-1:0]       low_edge_o,
  output logic [LineW-1:0]       high_edge_o,
  output logic                   last_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [CfgW-1:0]   cfg_data_i
);

  localparam int unsigned Xw  = (MAX_WIDTH > 1)  ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned Yw  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned Ww  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned Hw  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned Wcw = (Ww > CfgW) ? Ww : CfgW;
  localparam int unsigned Hcw = (Hw > CfgW) ? Hw : CfgW;
  localparam logic [Ww-1:0] WidthReset  =
    Ww'((MAX_WIDTH < SizeResetVal) ? MAX_WIDTH : SizeResetVal);
  localparam logic [Hw-1:0] HeightReset =
    Hw'((MAX_HEIGHT < SizeResetVal) ? MAX_HEIGHT : SizeResetVal);

  // Configuration
  logic [Ww-1:0]     width_q, width_d;
  logic [Hw-1:0]     height_q, height_d;
  logic [AlphaW-1:0] thresh_q, thresh_d;
  logic [Wcw-1:0]    cfg_w_ext;
  logic [Hcw-1:0]    cfg_h_ext;
  logic              cfg_we;

  // Position and row extents
  logic [Xw-1:0]    col_pos_q, col_pos_d;
  logic [Yw-1:0]    row_pos_q, row_pos_d;
  logic             row_found_q, row_found_d;
  logic [LineW-1:0] row_first_q, row_first_d;
  logic [LineW-1:0] row_final_q, row_final_d;

  logic             in_accept;
  logic             full;
  logic             row_end;
  logic             top;
  logic [LineW-1:0] x_line;
  logic             found_now;
  logic [LineW-1:0] first_now;
  logic [LineW-1:0] final_now;
  col_req_t         col_req;

  // Second stage
  logic             s1_valid_q;
  logic             s1_top_q;
  logic             s1_row_end_q;
  result_t          s1_row_q;
  result_t          row_res;
  result_t          col_res;
  result_t          push0;
  logic [1:0]       push_cnt;

  // Output queue
  result_t             head_res;
  logic [FifoCntW-1:0] fifo_count;
  logic                out_accept;
  logic [FifoCntW:0]   need;

  // Config write decode, with size clamping
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_w_ext   = Wcw'(cfg_data_i);
  assign cfg_h_ext   = Hcw'(cfg_data_i);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    thresh_d = thresh_q;
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH: begin
          if (cfg_w_ext == '0) begin
            width_d = Ww'(1);
          end else if (cfg_w_ext > Wcw'(MAX_WIDTH)) begin
            width_d = Ww'(MAX_WIDTH);
          end else begin
            width_d = Ww'(cfg_w_ext);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_h_ext == '0) begin
            height_d = Hw'(1);
          end else if (cfg_h_ext > Hcw'(MAX_HEIGHT)) begin
            height_d = Hw'(MAX_HEIGHT);
          end else begin
            height_d = Hw'(cfg_h_ext);
          end
        end
        REG_ALPHA_THRESHOLD: begin
          thresh_d = cfg_data_i[AlphaW-1:0];
        end
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  // Hold the input while the queue could not absorb this pixel and the one
  // in the second stage
  assign need       = (FifoCntW + 1)'(fifo_count) + (FifoCntW + 1)'(push_cnt)
                    + (FifoCntW + 1)'(2);
  assign in_stall_o = need > (FifoCntW + 1)'(FifoDepth);
  assign in_accept  = in_valid_i && !in_stall_o;

  // First stage: classify the pixel and merge row extents
  assign full    = alpha_i > thresh_q;
  assign row_end = (Ww'(col_pos_q) + Ww'(1)) >= width_q;
  assign top     = (Hw'(row_pos_q) + Hw'(1)) >= height_q;
  assign x_line  = LineW'(col_pos_q);

  always_comb begin
    found_now = row_found_q || full;
    first_now = (full && !row_found_q) ? x_line : row_first_q;
    final_now = full ? x_line : row_final_q;
  end

  always_comb begin
    row_found_d = row_found_q;
    row_first_d = row_first_q;
    row_final_d = row_final_q;
    col_pos_d   = col_pos_q;
    row_pos_d   = row_pos_q;
    if (in_accept) begin
      if (row_end) begin
        row_found_d = 1'b0;
        row_first_d = '0;
        row_final_d = '0;
        col_pos_d   = '0;
        row_pos_d   = top ? '0 : row_pos_q + Yw'(1);
      end else begin
        row_found_d = found_now;
        row_first_d = first_now;
        row_final_d = final_now;
        col_pos_d   = col_pos_q + Xw'(1);
      end
    end
  end

  always_comb begin
    row_res            = '0;
    row_res.kind       = KIND_ROW;
    row_res.line_index = LineW'(row_pos_q);
    row_res.present    = found_now;
    row_res.low_edge   = found_now ? first_now : '0;
    row_res.high_edge  = found_now ? final_now : '0;
    row_res.last       = 1'b1;
  end

  always_comb begin
    col_req           = '0;
    col_req.first_row = (row_pos_q == '0);
    col_req.full      = full;
    col_req.row       = LineW'(row_pos_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= WidthReset;
      height_q     <= HeightReset;
      thresh_q     <= '0;
      col_pos_q    <= '0;
      row_pos_q    <= '0;
      row_found_q  <= 1'b0;
      row_first_q  <= '0;
      row_final_q  <= '0;
      s1_valid_q   <= 1'b0;
      s1_top_q     <= 1'b0;
      s1_row_end_q <= 1'b0;
    end else begin
      width_q      <= width_d;
      height_q     <= height_d;
      thresh_q     <= thresh_d;
      col_pos_q    <= col_pos_d;
      row_pos_q    <= row_pos_d;
      row_found_q  <= row_found_d;
      row_first_q  <= row_first_d;
      row_final_q  <= row_final_d;
      s1_valid_q   <= in_accept;
      if (in_accept) begin
        s1_top_q     <= top;
        s1_row_end_q <= row_end;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_row_q <= row_res;
    end
  end

  // Column store: read now, merge and write back in the second stage
  amee_col_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_col_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_accept),
    .req_addr_i  (col_pos_q),
    .req_i       (col_req),
    .col_result_o(col_res)
  );

  // Second stage: column item first, row item second
  always_comb begin
    push_cnt = '0;
    if (s1_valid_q) begin
      push_cnt = 2'(s1_top_q) + 2'(s1_row_end_q);
    end
    if (s1_top_q) begin
      push0      = col_res;
      push0.last = !s1_row_end_q;
    end else begin
      push0 = s1_row_q;
    end
  end

  assign out_accept = out_valid_o && !out_stall_i;

  amee_result_fifo u_result_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(push_cnt),
    .wdata0_i  (push0),
    .wdata1_i  (s1_row_q),
    .pop_i     (out_accept),
    .rdata_o   (head_res),
    .count_o   (fifo_count)
  );

  assign out_valid_o  = (fifo_count != '0);
  assign kind_o       = head_res.kind;
  assign line_index_o = head_res.line_index;
  assign present_o    = head_res.present;
  assign low_edge_o   = head_res.low_edge;
  assign high_edge_o  = head_res.high_edge;
  assign last_o       = head_res.last;

  a_wrap_at_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && row_end) |=> (col_pos_q == '0))
    else $error("column position did not wrap at row end");

  a_advance_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !row_end) |=> (col_pos_q == $past(col_pos_q) + Xw'(1)))
    else $error("column position did not advance");

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import amee_pkg::*;

  localparam int          IDLE_PCT      = 38;      // idle / stall odds, percent per cycle
  localparam int          RANDOM_PIXELS = 200;     // random part stops after this many pixels
  localparam int          HOLD_AT       = 150;     // start the long output hold-off here
  localparam int          HOLD_CYCLES   = 120;
  localparam int          SETTLE_CYCLES = 6;       // pipeline latency plus margin
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          COLUMN_ROWS   = 64;      // rows of the single-column frame
  localparam int          PREDICT       = -1;      // plan row checked against the predictor
  localparam result_t     NO_RESULT     = '0;

  typedef enum logic { STEP_CFG, STEP_PIXEL } step_kind_e;
  typedef enum int { MIX_UNIFORM, MIX_NEAR, MIX_SPARSE, MIX_DENSE } alpha_mix_e;

  // One row of the directed plan: a register write or a pixel, with the items
  // it must cause typed in where they are obvious
  typedef struct packed {
    step_kind_e      op;
    cfg_reg_e        reg_idx;
    logic [CfgW-1:0] value;
    logic [AlphaW-1:0] alpha;
    int              want_n;
    result_t         want0;
    result_t         want1;
  } plan_step_t;

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [AlphaW-1:0] alpha_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              kind_o;
  logic [LineW-1:0]  line_index_o;
  logic              present_o;
  logic [LineW-1:0]  low_edge_o;
  logic [LineW-1:0]  high_edge_o;
  logic              last_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [CfgW-1:0]   cfg_data_i = '0;

  // Typed expectations that travel with the pixel on offer
  int                typed_n = PREDICT;
  result_t           typed_first = '0;
  result_t           typed_second = '0;

  // Shadow registers of the block
  bit [CfgW-1:0]     width_reg = SizeResetVal;
  bit [CfgW-1:0]     height_reg = SizeResetVal;
  bit [AlphaW-1:0]   thresh_reg = '0;

  // Shadow scan position, running row extents and column store
  int unsigned       col_at = 0;
  int unsigned       row_at = 0;
  bit                row_any = 1'b0;
  bit [LineW-1:0]    row_lo = '0;
  bit [LineW-1:0]    row_hi = '0;
  bit                col_any [MaxWidth];
  bit [LineW-1:0]    col_lo [MaxWidth];
  bit [LineW-1:0]    col_hi [MaxWidth];
  // Frame number in which row 0 last wrote each column
  int unsigned       col_frame [MaxWidth];
  int unsigned       frame_no = 1;

  result_t           expected_extents [$];
  plan_step_t        plan [$];
  int                mismatches = 0;
  int                items_out = 0;
  int                pixels_taken = 0;
  int                cycle_count = 0;
  bit                calm = 1'b0;

  alpha_mask_edge_extents_unit DUT (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .alpha_i      (alpha_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .line_index_o (line_index_o),
    .present_o    (present_o),
    .low_edge_o   (low_edge_o),
    .high_edge_o  (high_edge_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic int unsigned eff_size(bit [CfgW-1:0] v, int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic result_t extent(kind_e k, int unsigned line, bit present,
                                     int unsigned lo, int unsigned hi, bit last);
    result_t r;
    r.kind       = k;
    r.line_index = LineW'(line);
    r.present    = present;
    r.low_edge   = present ? LineW'(lo) : '0;
    r.high_edge  = present ? LineW'(hi) : '0;
    r.last       = last;
    return r;
  endfunction

  // Advance the shadow state by one pixel and return the items it causes:
  // a column item on every pixel of the top row, then a row item at row end.
  task automatic predict_extents(input logic [AlphaW-1:0] a, output result_t first,
                                 output result_t second, output int n);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    bit          full;
    bit          row_end;
    bit          top;
    result_t     made [2];
    w       = eff_size(width_reg, MaxWidth);
    h       = eff_size(height_reg, MaxHeight);
    x       = col_at;
    y       = row_at;
    full    = a > thresh_reg;
    row_end = x + 1 >= w;
    top     = y + 1 >= h;
    n       = 0;
    made[0] = '0;
    made[1] = '0;
    if (full) begin
      if (!row_any) row_lo = LineW'(x);
      row_hi  = LineW'(x);
      row_any = 1'b1;
    end
    // Row 0 writes the column entry, later rows only widen it
    if (y == 0) begin
      col_any[x]   = full;
      col_lo[x]    = '0;
      col_hi[x]    = '0;
      col_frame[x] = frame_no;
    end else if (full) begin
      if (!col_any[x]) col_lo[x] = LineW'(y);
      col_hi[x]  = LineW'(y);
      col_any[x] = 1'b1;
    end
    if (top) begin
      made[n] = extent(KIND_COL, x, col_any[x], col_lo[x], col_hi[x], 1'b0);
      n++;
    end
    if (row_end) begin
      made[n] = extent(KIND_ROW, y, row_any, row_lo, row_hi, 1'b0);
      n++;
      row_any = 1'b0;
      row_lo  = '0;
      row_hi  = '0;
    end
    if (n > 0) made[n-1].last = 1'b1;
    if (row_end) begin
      col_at = 0;
      if (top) begin
        row_at = 0;
        frame_no++;
      end else begin
        row_at = y + 1;
      end
    end else begin
      col_at = x + 1;
    end
    first  = made[0];
    second = made[1];
  endtask

  // A new width is safe unless it makes a later row read a column that
  // row 0 of this frame never wrote
  function automatic bit width_fits(bit [CfgW-1:0] v);
    int unsigned w;
    w = eff_size(v, MaxWidth);
    if (row_at == 0) return 1'b1;
    if (col_frame[col_at] != frame_no) return 1'b0;
    for (int i = 0; i < w; i++) begin
      if (col_frame[i] != frame_no) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [LineW-1:0] got, logic [LineW-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("item %0d %s got %0d expected %0d", items_out, name, got, want));
  endtask

  // Predict on every accepted pixel, check every accepted item
  always @(posedge clk) begin : scoreboard
    result_t p0;
    result_t p1;
    result_t want;
    result_t seen;
    int      np;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        predict_extents(alpha_i, p0, p1, np);
        // Typed rows override the predictor's items, so only the typed items are checked
        if (typed_n != PREDICT) begin
          np = typed_n;
          p0 = typed_first;
          p1 = typed_second;
        end
        if (np > 0) expected_extents.push_back(p0);
        if (np > 1) expected_extents.push_back(p1);
        pixels_taken++;
      end
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        seen = {kind_o, line_index_o, present_o, low_edge_o, high_edge_o, last_o};
        if (expected_extents.size() == 0) begin
          report_mismatch($sformatf("item %0d arrived with nothing expected", items_out));
        end else begin
          want = expected_extents.pop_front();
          check_field("kind", seen.kind, want.kind);
          check_field("line_index", seen.line_index, want.line_index);
          check_field("present", seen.present, want.present);
          check_field("low_edge", seen.low_edge, want.low_edge);
          check_field("high_edge", seen.high_edge, want.high_edge);
          check_field("last", seen.last, want.last);
        end
        items_out++;
      end
    end
  end

  // Receiver: stall at random, hold off once for a long stretch so the
  // result queue fills and the input backs up; no random stalls while calm
  always @(negedge clk) begin : receiver
    static int hold_left = 0;
    static bit hold_done = 1'b0;
    if (!hold_done && pixels_taken >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Offer one pixel, idling first at random; return at the falling edge
  // after it was taken, with valid still high
  task automatic send_pixel(input logic [AlphaW-1:0] a, input int n_typed,
                            input result_t r0, input result_t r1);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i   <= 1'b1;
    alpha_i      <= a;
    typed_n      <= n_typed;
    typed_first  <= r0;
    typed_second <= r1;
    @(posedge clk);
    while (in_stall_o !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write a register once the block is idle: drop valid, wait for every
  // expected item, then let the pipeline settle
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] v);
    in_valid_i <= 1'b0;
    while (expected_extents.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk);
    while (cfg_ready_o !== 1'b1) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:     width_reg = v;
      REG_IMAGE_HEIGHT:    height_reg = v;
      REG_ALPHA_THRESHOLD: thresh_reg = v[AlphaW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic plan_step_t set_reg(cfg_reg_e idx, logic [CfgW-1:0] v);
    plan_step_t s;
    s         = '0;
    s.op      = STEP_CFG;
    s.reg_idx = idx;
    s.value   = v;
    return s;
  endfunction

  function automatic plan_step_t pixel(logic [AlphaW-1:0] a, int n, result_t r0, result_t r1);
    plan_step_t s;
    s        = '0;
    s.op     = STEP_PIXEL;
    s.alpha  = a;
    s.want_n = n;
    s.want0  = r0;
    s.want1  = r1;
    return s;
  endfunction

  function automatic bit [CfgW-1:0] pick_size(int unsigned common_max, int unsigned rare_max);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 80) return CfgW'($urandom_range(common_max, 1));
    return CfgW'($urandom_range(rare_max, common_max + 1));
  endfunction

  function automatic logic [CfgW-1:0] pick_thresh();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return CfgW'(255);
    return CfgW'($urandom_range(255));
  endfunction

  // Shape the alpha stream: uniform, hugging the threshold, mostly empty
  // or mostly full
  function automatic logic [AlphaW-1:0] pick_alpha(alpha_mix_e mix);
    int t;
    int v;
    t = thresh_reg;
    case (mix)
      MIX_NEAR: begin
        v = t + int'($urandom_range(2)) - 1;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return AlphaW'(v);
      end
      MIX_SPARSE: begin
        if ($urandom_range(9) == 0) return AlphaW'($urandom_range(255));
        return AlphaW'($urandom_range(t, 0));
      end
      MIX_DENSE: begin
        if ($urandom_range(9) == 0) return AlphaW'($urandom_range(255));
        return AlphaW'($urandom_range(255, (t < 255) ? t + 1 : 255));
      end
      default: return AlphaW'($urandom_range(255));
    endcase
  endfunction

  initial begin : stimulus
    int          random_pixels;
    int          count;
    int          rest;
    int unsigned w;
    int unsigned h;
    bit [CfgW-1:0] new_width;
    alpha_mix_e  mix;

    // Hold reset, then release it on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // 3x2 frame, threshold 0x80: an alpha equal to the threshold is not full
    plan.push_back(set_reg(REG_IMAGE_WIDTH, 11'd3));
    plan.push_back(set_reg(REG_IMAGE_HEIGHT, 11'd2));
    plan.push_back(set_reg(REG_ALPHA_THRESHOLD, 11'h080));
    plan.push_back(pixel(8'h00, 0, NO_RESULT, NO_RESULT));
    plan.push_back(pixel(8'hFF, 0, NO_RESULT, NO_RESULT));
    plan.push_back(pixel(8'h80, 1, extent(KIND_ROW, 0, 1, 1, 1, 1), NO_RESULT));
    plan.push_back(pixel(8'h81, 1, extent(KIND_COL, 0, 1, 1, 1, 1), NO_RESULT));
    plan.push_back(pixel(8'h00, 1, extent(KIND_COL, 1, 1, 0, 0, 1), NO_RESULT));
    plan.push_back(pixel(8'hFF, 2, extent(KIND_COL, 2, 1, 1, 1, 0),
                         extent(KIND_ROW, 1, 1, 0, 2, 1)));
    // Height 0 acts as a single-row frame: each column reports its one pixel
    plan.push_back(set_reg(REG_IMAGE_WIDTH, 11'd2));
    plan.push_back(set_reg(REG_IMAGE_HEIGHT, 11'd0));
    plan.push_back(set_reg(REG_ALPHA_THRESHOLD, 11'd0));
    plan.push_back(pixel(8'h00, 1, extent(KIND_COL, 0, 0, 0, 0, 1), NO_RESULT));
    plan.push_back(pixel(8'h01, 2, extent(KIND_COL, 1, 1, 0, 0, 0),
                         extent(KIND_ROW, 0, 1, 1, 1, 1)));
    // 1x1 frame at the top thresholds: nothing can exceed 255
    plan.push_back(set_reg(REG_IMAGE_WIDTH, 11'd1));
    plan.push_back(set_reg(REG_ALPHA_THRESHOLD, 11'd255));
    plan.push_back(pixel(8'hFF, 2, extent(KIND_COL, 0, 0, 0, 0, 0),
                         extent(KIND_ROW, 0, 0, 0, 0, 1)));
    plan.push_back(pixel(8'h00, 2, extent(KIND_COL, 0, 0, 0, 0, 0),
                         extent(KIND_ROW, 0, 0, 0, 0, 1)));
    plan.push_back(set_reg(REG_ALPHA_THRESHOLD, 11'd254));
    plan.push_back(pixel(8'hFF, 2, extent(KIND_COL, 0, 1, 0, 0, 0),
                         extent(KIND_ROW, 0, 1, 0, 0, 1)));
    // Shrink the width mid-row past the scan position, then the height
    // mid-frame below the current row
    plan.push_back(set_reg(REG_IMAGE_WIDTH, 11'd4));
    plan.push_back(set_reg(REG_IMAGE_HEIGHT, 11'd3));
    plan.push_back(set_reg(REG_ALPHA_THRESHOLD, 11'd0));
    plan.push_back(pixel(8'h01, PREDICT, NO_RESULT, NO_RESULT));
    plan.push_back(pixel(8'h00, PREDICT, NO_RESULT, NO_RESULT));
    plan.push_back(pixel(8'h00, PREDICT, NO_RESULT, NO_RESULT));
    plan.push_back(pixel(8'h05, PREDICT, NO_RESULT, NO_RESULT));
    plan.push_back(pixel(8'h00, PREDICT, NO_RESULT, NO_RESULT));
    plan.push_back(pixel(8'h07, PREDICT, NO_RESULT, NO_RESULT));
    plan.push_back(set_reg(REG_IMAGE_WIDTH, 11'd2));
    plan.push_back(pixel(8'h09, PREDICT, NO_RESULT, NO_RESULT));
    plan.push_back(set_reg(REG_IMAGE_HEIGHT, 11'd1));
    plan.push_back(pixel(8'h00, PREDICT, NO_RESULT, NO_RESULT));
    plan.push_back(pixel(8'h00, PREDICT, NO_RESULT, NO_RESULT));

    foreach (plan[i]) begin
      if (plan[i].op == STEP_CFG) write_reg(plan[i].reg_idx, plan[i].value);
      else send_pixel(plan[i].alpha, plan[i].want_n, plan[i].want0, plan[i].want1);
    end

    // Widest frame, one row, with no idling on either side: every pixel
    // reports its column, the receiver holds off partway through while
    // pixels keep coming
    write_reg(REG_IMAGE_WIDTH, 11'd2047);
    write_reg(REG_IMAGE_HEIGHT, 11'd1);
    write_reg(REG_ALPHA_THRESHOLD, 11'h07F);
    calm = 1'b1;
    repeat (MaxWidth) send_pixel(AlphaW'($urandom_range(255)), PREDICT, NO_RESULT, NO_RESULT);

    // Single-column frame, still with no idling: the same entry is read
    // back to back
    write_reg(REG_IMAGE_WIDTH, 11'd1);
    write_reg(REG_IMAGE_HEIGHT, CfgW'(COLUMN_ROWS));
    repeat (COLUMN_ROWS) send_pixel(AlphaW'($urandom_range(255)), PREDICT, NO_RESULT, NO_RESULT);
    calm = 1'b0;

    // Random phases: small frames, register changes between phases, often
    // mid-frame; finish the frame half the time
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      if ($urandom_range(1) == 1) begin
        new_width = pick_size(8, 24);
        if (width_fits(new_width)) write_reg(REG_IMAGE_WIDTH, new_width);
      end
      if ($urandom_range(1) == 1) write_reg(REG_IMAGE_HEIGHT, pick_size(6, 16));
      if ($urandom_range(2) == 0) write_reg(REG_ALPHA_THRESHOLD, pick_thresh());
      mix = alpha_mix_e'($urandom_range(3));
      if ($urandom_range(1) == 1) begin
        w    = eff_size(width_reg, MaxWidth);
        h    = eff_size(height_reg, MaxHeight);
        rest = int'(w * h) - int'(row_at * w + col_at);
        if (rest < 1) rest = 1;
        if (rest > 300) rest = 300;
        count = rest;
      end else begin
        count = $urandom_range(40, 1);
      end
      repeat (count) send_pixel(pick_alpha(mix), PREDICT, NO_RESULT, NO_RESULT);
      random_pixels += count;
    end

    // Drain, then give stray items a chance to show up
    in_valid_i <= 1'b0;
    while (expected_extents.size() != 0) @(negedge clk);
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
